// File: src/ppq_pkg.sv
package ppq_pkg;

  // Color modes
  localparam logic [1:0] MODE_BW      = 2'd0;
  localparam logic [1:0] MODE_RED     = 2'd1;
  localparam logic [1:0] MODE_YEL_RED = 2'd2;
  localparam logic [1:0] MODE_GRAY4   = 2'd3;

  // Source pixel formats; codes above SF_32BPP behave as 24 bpp.
  localparam logic [2:0] SF_4BPP  = 3'd0;
  localparam logic [2:0] SF_8BPP  = 3'd1;
  localparam logic [2:0] SF_565   = 3'd2;
  localparam logic [2:0] SF_24BPP = 3'd3;
  localparam logic [2:0] SF_32BPP = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLOR_MODE    = 2'd0;
  localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd1;
  localparam logic [1:0] CFG_USE_PALETTE   = 2'd2;

  // Input opcodes
  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_CONVERT   = 1'b1;

  // Threshold constants of the color rules
  localparam logic [7:0] GRAY_LIGHT   = 8'd100;
  localparam logic [7:0] GRAY_DARK_YR = 8'd90;
  localparam logic [7:0] CHAN_DARK    = 8'd80;
  localparam logic [8:0] CHAN_MARGIN  = 9'd32;
  localparam logic [7:0] MASK_565_R   = 8'hf8;
  localparam logic [7:0] MASK_565_G   = 8'hfc;

  // Quantizer result handed to the packer.
  typedef struct packed {
    logic [1:0] code;
    logic       two_bit;
  } qres_t;

  // Gray level (r + 2g + b) / 4.
  function automatic logic [7:0] gray_level(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    logic [9:0] sum;
    sum = {2'b00, r} + {1'b0, g, 1'b0} + {2'b00, b};
    return sum[9:2];
  endfunction

  // True when a exceeds c by more than the color margin.
  function automatic logic exceeds(input logic [7:0] a, input logic [7:0] c);
    return {1'b0, a} > ({1'b0, c} + CHAN_MARGIN);
  endfunction

  // Black-white-red rule.
  function automatic logic [1:0] code_bwr(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    logic [7:0] gr;
    logic [1:0] c;
    gr = gray_level(r, g, b);
    if (r > g && r > b) begin
      if (gr < GRAY_LIGHT && r < CHAN_DARK) c = 2'd0;
      else if (exceeds(r, b) && exceeds(r, g)) c = 2'd3;
      else c = 2'd1;
    end else begin
      c = (gr >= GRAY_LIGHT) ? 2'd1 : 2'd0;
    end
    return c;
  endfunction

  // Black-white-yellow-red rule.
  function automatic logic [1:0] code_bwyr(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [7:0] gr;
    logic [1:0] c;
    gr = gray_level(r, g, b);
    if (r > b || g > b) begin
      if (gr < GRAY_DARK_YR && r < CHAN_DARK && g < CHAN_DARK) c = 2'd0;
      else if (exceeds(r, b) && exceeds(r, g)) c = 2'd3;
      else if (exceeds(r, b) && exceeds(g, b)) c = 2'd2;
      else c = 2'd1;
    end else begin
      c = (gr >= GRAY_LIGHT) ? 2'd1 : 2'd0;
    end
    return c;
  endfunction

endpackage

// File: src/pixel_palette_quantize_pack.sv
// Pipeline: an accepted pixel is held in stage 1 (s1 registers and palette read data),
// then its byte, if any, goes to the m_tdata output register.
// Throughput: one item per cycle while the output is not stalled; each item writes or
// reads the palette memory in its accept cycle.
// Reset (rst, synchronous): packing state, pipeline valids and configuration return to
// their defaults; palette contents are undefined until written and are not cleared.
module pixel_palette_quantize_pack import ppq_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  // Input pixel stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [7:0] palette_index, [31:8] pixel
  input  logic        s_tuser,   // [0] opcode
  input  logic        s_tlast,   // last_in_row
  // Output byte stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] packed_byte
  output logic        m_tlast    // row_end
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  logic [1:0] color_mode;
  logic [2:0] source_format;
  logic       use_palette;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode    <= MODE_BW;
      source_format <= SF_24BPP;
      use_palette   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLOR_MODE:    color_mode    <= cfg_data[1:0];
        CFG_SOURCE_FORMAT: source_format <= cfg_data;
        CFG_USE_PALETTE:   use_palette   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic       in_fire, adv;
  logic [7:0] pidx, rd_idx;
  logic       s1_valid, s1_last, s1_pal_ok;
  logic [23:0] s1_pixel, pal_rgb;

  // The pipeline moves when the output register is empty or being emptied.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || adv;
  assign in_fire  = s_tvalid && s_tready;
  assign pidx     = s_tdata[7:0];
  assign rd_idx   = (source_format == SF_4BPP) ? {4'h0, s_tdata[11:8]} : s_tdata[15:8];

  ppq_palette #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .we    (in_fire && s_tuser == OP_PAL_WRITE && {1'b0, pidx} < DEPTH9),
    .waddr (pidx[AW-1:0]),
    .wdata (s_tdata[31:8]),
    .re    (in_fire && s_tuser == OP_CONVERT),
    .raddr (rd_idx[AW-1:0]),
    .rdata (pal_rgb)
  );

  // Stage 1: convert item waiting for its palette data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= (s_tuser == OP_CONVERT);
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_pixel  <= s_tdata[31:8];
      s1_last   <= s_tlast;
      s1_pal_ok <= {1'b0, rd_idx} < DEPTH9;
    end
  end

  qres_t q;

  ppq_quantize u_quantize (
    .pixel         (s1_pixel),
    .pal_rgb       (pal_rgb),
    .pal_ok        (s1_pal_ok),
    .color_mode    (color_mode),
    .source_format (source_format),
    .use_palette   (use_palette),
    .res           (q)
  );

  logic [7:0] acc, acc_next, out_byte;
  logic [3:0] rem, rem_next, dbpp;
  logic       emit, full;

  // Shift the code in and decide whether a byte leaves.
  always_comb begin
    dbpp     = q.two_bit ? 4'd2 : 4'd1;
    acc_next = q.two_bit ? {acc[5:0], q.code} : {acc[6:0], q.code[0]};
    rem_next = (rem > dbpp) ? (rem - dbpp) : 4'd0;
    full     = (rem_next == 4'd0);
    emit     = full || s1_last;
    out_byte = full ? acc_next : (acc_next << rem_next[2:0]);
  end

  // Packing state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= 8'd0;
      rem      <= 4'd8;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s1_valid && adv) begin
        if (emit) begin
          acc      <= 8'd0;
          rem      <= 4'd8;
          m_tvalid <= 1'b1;
        end else begin
          acc <= acc_next;
          rem <= rem_next;
        end
      end
    end
    if (s1_valid && adv && emit) begin
      m_tdata <= out_byte;
      m_tlast <= s1_last;
    end
  end

  // Bits remaining always lies between one and eight.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rem != 4'd0 && rem <= 4'd8)
    else $error("bits remaining out of range");

  // Reset leaves an empty pipeline and a fresh byte.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!s1_valid && !m_tvalid && rem == 4'd8 && acc == 8'd0))
    else $error("bad state after reset");

  // A stalled output keeps the stage-1 item in place.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |=> (s1_valid && $stable(s1_pixel)))
    else $error("stage 1 item lost under stall");

endmodule

// File: src/ppq_palette.sv
module ppq_palette import ppq_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] waddr,
  input  logic [23:0]                      wdata,
  input  logic                             re,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] raddr,
  output logic [23:0]                      rdata
);

  logic [23:0] mem [PALETTE_DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/ppq_quantize.sv
module ppq_quantize import ppq_pkg::*; (
  input  logic [23:0] pixel,
  input  logic [23:0] pal_rgb,
  input  logic        pal_ok,
  input  logic [1:0]  color_mode,
  input  logic [2:0]  source_format,
  input  logic        use_palette,
  output qres_t       res
);

  logic [7:0] r, g, b, v, gray;

  // Expand the source pixel to red, green and blue.
  always_comb begin
    v = (source_format == SF_4BPP) ? {pixel[3:0], pixel[3:0]} : pixel[7:0];
    case (source_format)
      SF_4BPP, SF_8BPP: begin
        if (use_palette) begin
          r = pal_ok ? pal_rgb[7:0]   : 8'd0;
          g = pal_ok ? pal_rgb[15:8]  : 8'd0;
          b = pal_ok ? pal_rgb[23:16] : 8'd0;
        end else begin
          r = v;
          g = v;
          b = v;
        end
      end
      SF_565: begin
        r = pixel[15:8] & MASK_565_R;
        g = pixel[10:3] & MASK_565_G;
        b = {pixel[4:0], 3'b000};
      end
      default: begin
        r = pixel[7:0];
        g = pixel[15:8];
        b = pixel[23:16];
      end
    endcase
  end

  // Reduce to a 1- or 2-bit code.
  always_comb begin
    gray = gray_level(r, g, b);
    res.two_bit = (color_mode != MODE_BW);
    case (color_mode)
      MODE_BW:    res.code = {1'b0, gray[7]};
      MODE_GRAY4: res.code = gray[7:6];
      MODE_RED:   res.code = code_bwr(r, g, b);
      default:    res.code = code_bwyr(r, g, b);
    endcase
  end

endmodule
